// File: design/tracking_confidence_gate_fade_defines.svh
// assertion macros shared by the gate and fade modules
`ifndef TRACKING_CONFIDENCE_GATE_FADE_DEFINES_SVH
`define TRACKING_CONFIDENCE_GATE_FADE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TCGF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCGF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tcgf_pkg.sv
package tcgf_pkg;

    // default parameter values
    localparam int DEF_TIME_BITS     = 32;
    localparam int DEF_VIS_FRAC_BITS = 15;

    // fixed field widths
    localparam int STAMP_W    = 32;
    localparam int CONF_W     = 8;
    localparam int RUN_W      = 8;
    localparam int HOLD_W     = 16;
    localparam int DUR_W      = 16;
    localparam int VIS_OUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_TIME  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_TIME = 3'd6;

    // register reset values
    localparam logic              RST_ENABLE        = 1'b1;
    localparam logic [CONF_W-1:0] RST_CONF_HIGH     = 8'd179;
    localparam logic [CONF_W-1:0] RST_CONF_LOW      = 8'd128;
    localparam logic [RUN_W-1:0]  RST_LOW_LIMIT     = 8'd3;
    localparam logic [HOLD_W-1:0] RST_HOLD_LIMIT    = 16'd5;
    localparam logic [DUR_W-1:0]  RST_FADE_IN_TIME  = 16'd150;
    localparam logic [DUR_W-1:0]  RST_FADE_OUT_TIME = 16'd300;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;     // latch the input transaction
        logic gate;        // hysteresis, hold counter, timestamp
        logic begin_ramp;  // switch ramp direction
        logic snap;        // zero-duration ramp, jump to the end level
        logic mul;         // level times duration
        logic origin;      // back-computed ramp start
        logic elapsed;     // elapsed time and divider setup
        logic div_step;    // one quotient bit
        logic apply;       // write the new level
        logic load_out;    // fill the output register
    } t_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic en;          // stabilizer enabled
        logic start;       // a new ramp begins this frame
        logic dur_zero;    // duration of the active direction is zero
        logic keep_ramp;   // a ramp level must be evaluated
        logic ge_dur;      // elapsed time reached the duration
    } t_status;

endpackage

// File: design/tcgf_ctrl.sv
`include "tracking_confidence_gate_fade_defines.svh"

module tcgf_ctrl #(
    parameter int VIS_FRAC_BITS = tcgf_pkg::DEF_VIS_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tcgf_pkg::t_status i_status,
    output tcgf_pkg::t_cmd    o_cmd
);
    import tcgf_pkg::*;

    localparam int              CNT_W    = $clog2(VIS_FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VIS_FRAC_BITS - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_GATE   = 10'b0000000010,
        S_PLAN   = 10'b0000000100,
        S_SNAP   = 10'b0000001000,
        S_MUL    = 10'b0000010000,
        S_ORIGIN = 10'b0000100000,
        S_ELAP   = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_APPLY  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_GATE;
                end
            end
            S_GATE: begin
                cmd.gate = 1'b1;
                n_state  = S_PLAN;
            end
            S_PLAN: begin
                if (!i_status.en) begin
                    n_state = S_OUT;
                end else if (i_status.start) begin
                    cmd.begin_ramp = 1'b1;
                    n_state        = i_status.dur_zero ? S_SNAP : S_MUL;
                end else if (i_status.keep_ramp) begin
                    n_state = i_status.dur_zero ? S_SNAP : S_ELAP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SNAP: begin
                cmd.snap = 1'b1;
                n_state  = S_OUT;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_ORIGIN;
            end
            S_ORIGIN: begin
                cmd.origin = 1'b1;
                n_state    = S_ELAP;
            end
            S_ELAP: begin
                cmd.elapsed = 1'b1;
                if (i_status.ge_dur) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt   = CNT_LAST;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_APPLY: begin
                cmd.apply = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `TCGF_ASSERT_NEXT(a_accept_to_gate, i_in_valid && o_in_ready, r_state == S_GATE, "accepted transaction did not enter the gate step")
    `TCGF_ASSERT_NEXT(a_div_ends, (r_state == S_DIV) && (r_cnt == '0), r_state == S_APPLY, "divider overran its bit count")
    `TCGF_ASSERT_NOW(a_no_overwrite, cmd.load_out, !r_out_valid || i_out_ready, "output register overwritten before it was taken")

endmodule

// File: design/tcgf_dp.sv
`include "tracking_confidence_gate_fade_defines.svh"

module tcgf_dp #(
    parameter int TIME_BITS     = tcgf_pkg::DEF_TIME_BITS,
    parameter int VIS_FRAC_BITS = tcgf_pkg::DEF_VIS_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [tcgf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcgf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_detect_in,
    input  logic [tcgf_pkg::CONF_W-1:0]         i_conf_in,
    input  logic [tcgf_pkg::STAMP_W-1:0]        i_time_ms,
    input  tcgf_pkg::t_cmd                      i_cmd,
    output tcgf_pkg::t_status                   o_status,
    output logic                                o_accepted,
    output logic                                o_holding,
    output logic                                o_lost_out,
    output logic [tcgf_pkg::VIS_OUT_W-1:0]      o_visibility_level,
    output logic                                o_smoothing_reset,
    output logic [tcgf_pkg::STAMP_W-1:0]        o_last_valid_time
);
    import tcgf_pkg::*;

    localparam int F  = VIS_FRAC_BITS;
    localparam int TB = TIME_BITS;
    localparam int VW = F + 1;
    localparam int PW = VW + DUR_W;
    localparam logic [VW-1:0] VIS_ONE   = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0] PROD_HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    // configuration registers
    logic              r_en;
    logic [CONF_W-1:0] r_conf_high, r_conf_low;
    logic [RUN_W-1:0]  r_low_lim;
    logic [HOLD_W-1:0] r_hold_lim;
    logic [DUR_W-1:0]  r_fade_in, r_fade_out;

    // latched transaction
    logic              r_det;
    logic [CONF_W-1:0] r_conf;
    logic [TB-1:0]     r_t;

    // tracker state
    logic               r_tracking, r_seen, r_ramp_in, r_ramp_out;
    logic [RUN_W-1:0]   r_low_run;
    logic [HOLD_W-1:0]  r_frames_inv;
    logic [STAMP_W-1:0] r_stamp;
    logic [VW-1:0]      r_vis;
    logic [TB-1:0]      r_ramp_start;

    // per-frame working registers
    logic               r_valid, r_hold, r_pulse;
    logic [STAMP_W-1:0] r_last;
    logic [PW-1:0]      r_prod;
    logic [DUR_W-1:0]   r_rem;
    logic [VW-1:0]      r_frac;

    // output register
    logic                 r_o_accepted, r_o_holding, r_o_lost, r_o_reset;
    logic [VIS_OUT_W-1:0] r_o_vis;
    logic [STAMP_W-1:0]   r_o_last;

    logic               g_valid, g_track, g_hold;
    logic [RUN_W-1:0]   g_low_run, low_run_inc;
    logic [HOLD_W-1:0]  fi_inc;
    logic [STAMP_W-1:0] stamp32, last_prev;
    logic [DUR_W-1:0]   dur;
    logic [VW-1:0]      mul_frac, fade_out_lvl;
    logic [PW-1:0]      back_sum;
    logic [TB-1:0]      origin, elapsed;
    logic [DUR_W:0]     rem2, rem_diff;
    logic               rem_fits, clear_req;

    // hysteresis gate
    assign low_run_inc = (r_low_run == '1) ? r_low_run : r_low_run + 1'b1;

    always_comb begin
        g_valid   = r_det;
        g_track   = r_tracking;
        g_low_run = r_low_run;
        if (r_det) begin
            if (r_tracking) begin
                if (r_conf < r_conf_low) begin
                    g_low_run = low_run_inc;
                    if (low_run_inc >= r_low_lim) begin
                        g_track = 1'b0;
                        g_valid = 1'b0;
                    end
                end else begin
                    g_low_run = '0;
                end
            end else if (r_conf >= r_conf_high) begin
                g_track   = 1'b1;
                g_low_run = '0;
            end else begin
                g_valid = 1'b0;
            end
        end else begin
            g_track   = 1'b0;
            g_low_run = '0;
        end
    end

    // dropout hold
    assign fi_inc    = (r_frames_inv == '1) ? r_frames_inv : r_frames_inv + 1'b1;
    assign g_hold    = r_seen && (fi_inc <= r_hold_lim);
    assign stamp32   = STAMP_W'(r_t);
    assign last_prev = r_seen ? r_stamp : '0;

    // ramp arithmetic
    assign dur          = r_valid ? r_fade_in : r_fade_out;
    assign mul_frac     = r_valid ? r_vis : VIS_ONE - r_vis;
    assign back_sum     = r_prod + PROD_HALF;
    assign origin       = r_t - TB'(back_sum[PW-1:F]);
    assign elapsed      = r_t - r_ramp_start;
    assign fade_out_lvl = VIS_ONE - r_frac;

    // restoring divider step
    assign rem2     = {r_rem, 1'b0};
    assign rem_diff = rem2 - {1'b0, dur};
    assign rem_fits = (rem2 >= {1'b0, dur});

    assign clear_req = (i_cfg_valid && (i_cfg_index == CFG_ENABLE) && !i_cfg_data[0])
                    || (i_cmd.gate && !r_en);

    assign o_status.en        = r_en;
    assign o_status.start     = r_valid ? !r_ramp_in : (!r_ramp_out && (r_vis != '0));
    assign o_status.dur_zero  = (dur == '0);
    assign o_status.keep_ramp = r_valid || r_ramp_out;
    assign o_status.ge_dur    = (elapsed >= TB'(dur));

    // configuration and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en         <= RST_ENABLE;
            r_conf_high  <= RST_CONF_HIGH;
            r_conf_low   <= RST_CONF_LOW;
            r_low_lim    <= RST_LOW_LIMIT;
            r_hold_lim   <= RST_HOLD_LIMIT;
            r_fade_in    <= RST_FADE_IN_TIME;
            r_fade_out   <= RST_FADE_OUT_TIME;
            r_tracking   <= 1'b0;
            r_low_run    <= '0;
            r_frames_inv <= '0;
            r_seen       <= 1'b0;
            r_stamp      <= '0;
            r_vis        <= '0;
            r_ramp_start <= '0;
            r_ramp_in    <= 1'b0;
            r_ramp_out   <= 1'b0;
            r_valid      <= 1'b0;
            r_hold       <= 1'b0;
            r_last       <= '0;
            r_pulse      <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ENABLE:        r_en        <= i_cfg_data[0];
                    CFG_CONF_HIGH:     r_conf_high <= i_cfg_data[CONF_W-1:0];
                    CFG_CONF_LOW:      r_conf_low  <= i_cfg_data[CONF_W-1:0];
                    CFG_LOW_LIMIT:     r_low_lim   <= i_cfg_data[RUN_W-1:0];
                    CFG_HOLD_LIMIT:    r_hold_lim  <= i_cfg_data[HOLD_W-1:0];
                    CFG_FADE_IN_TIME:  r_fade_in   <= i_cfg_data[DUR_W-1:0];
                    CFG_FADE_OUT_TIME: r_fade_out  <= i_cfg_data[DUR_W-1:0];
                    default: ;
                endcase
            end

            // gate step
            if (i_cmd.gate) begin
                r_pulse <= 1'b0;
                if (!r_en) begin
                    r_valid <= r_det;
                    r_hold  <= 1'b0;
                    r_last  <= '0;
                end else begin
                    r_tracking <= g_track;
                    r_low_run  <= g_low_run;
                    r_valid    <= g_valid;
                    if (g_valid) begin
                        r_frames_inv <= '0;
                        r_seen       <= 1'b1;
                        r_stamp      <= stamp32;
                        r_last       <= stamp32;
                        r_hold       <= 1'b0;
                    end else begin
                        r_frames_inv <= fi_inc;
                        r_last       <= last_prev;
                        r_hold       <= g_hold;
                    end
                end
            end

            // ramp direction change
            if (i_cmd.begin_ramp) begin
                if (r_valid) begin
                    r_ramp_in  <= 1'b1;
                    r_ramp_out <= 1'b0;
                end else begin
                    r_ramp_out <= 1'b1;
                    r_ramp_in  <= 1'b0;
                end
                if (dur == '0) begin
                    r_ramp_start <= r_t;
                end
            end

            // instant ramp
            if (i_cmd.snap) begin
                if (r_valid) begin
                    r_vis     <= VIS_ONE;
                    r_ramp_in <= 1'b0;
                end else begin
                    r_vis      <= '0;
                    r_ramp_out <= 1'b0;
                    r_pulse    <= 1'b1;
                end
            end

            if (i_cmd.origin) begin
                r_ramp_start <= origin;
            end

            // new level from the ramp fraction
            if (i_cmd.apply) begin
                if (r_valid) begin
                    r_vis <= r_frac;
                    if (r_frac == VIS_ONE) begin
                        r_ramp_in <= 1'b0;
                    end
                end else begin
                    r_vis <= fade_out_lvl;
                    if (fade_out_lvl == '0) begin
                        r_ramp_out <= 1'b0;
                        r_pulse    <= 1'b1;
                    end
                end
            end

            // disable clears the tracker
            if (clear_req) begin
                r_tracking   <= 1'b0;
                r_low_run    <= '0;
                r_frames_inv <= '0;
                r_seen       <= 1'b0;
                r_stamp      <= '0;
                r_vis        <= '0;
                r_ramp_start <= '0;
                r_ramp_in    <= 1'b0;
                r_ramp_out   <= 1'b0;
            end
        end
    end

    // transaction latch, multiplier, divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_det  <= i_detect_in;
            r_conf <= i_conf_in;
            r_t    <= TB'(i_time_ms);
        end
        if (i_cmd.mul) begin
            r_prod <= mul_frac * dur;
        end
        if (i_cmd.elapsed) begin
            r_rem  <= elapsed[DUR_W-1:0];
            r_frac <= o_status.ge_dur ? VIS_ONE : '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_fits ? rem_diff[DUR_W-1:0] : rem2[DUR_W-1:0];
            r_frac <= {r_frac[VW-2:0], rem_fits};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_accepted <= r_valid;
            r_o_holding  <= r_hold;
            r_o_lost     <= !r_valid && !r_hold;
            r_o_reset    <= r_pulse;
            r_o_last     <= r_last;
            if (r_en) begin
                r_o_vis <= VIS_OUT_W'(r_vis);
            end else begin
                r_o_vis <= r_valid ? VIS_OUT_W'(VIS_ONE) : '0;
            end
        end
    end

    assign o_accepted         = r_o_accepted;
    assign o_holding          = r_o_holding;
    assign o_lost_out         = r_o_lost;
    assign o_visibility_level = r_o_vis;
    assign o_smoothing_reset  = r_o_reset;
    assign o_last_valid_time  = r_o_last;

    `TCGF_ASSERT_NOW(a_vis_range, 1'b1, r_vis <= VIS_ONE, "visibility above full scale")
    `TCGF_ASSERT_NOW(a_pulse_at_zero, r_pulse, r_vis == '0, "smoothing reset without zero visibility")
    `TCGF_ASSERT_NOW(a_rem_bound, i_cmd.div_step, r_rem < dur, "divider remainder out of range")

endmodule

// File: design/tracking_confidence_gate_fade.sv
// Face-tracking confidence gate with dropout hold and visibility fade. One
// input transaction per camera frame (detect flag, 8-bit confidence, ms
// timestamp) gives exactly one result transaction. Frames are handled one at
// a time. Each frame is captured, gated and planned and then loaded into the
// output register; a zero-length fade adds a jump to its end level, a fade in
// progress adds the elapsed-time step and the level update, and a fade that
// starts or resumes adds the multiply and origin steps before them. When the
// elapsed time does not yet cover the fade, the radix-2 divider runs between
// the elapsed-time step and the level update, producing one bit of
// elapsed/duration per cycle. A finished result waits in an output register,
// and the next frame is taken while it waits; a second result that is done
// before the first is taken holds the sequencer until the first one leaves.
// Registers are to be written by the user through the config channel only
// while no frame is in flight; the block itself does not enforce this.
// Writing 0 to enable clears all tracking and fade state. The config channel
// is always ready.
module tracking_confidence_gate_fade #(
    parameter int TIME_BITS     = tcgf_pkg::DEF_TIME_BITS,
    parameter int VIS_FRAC_BITS = tcgf_pkg::DEF_VIS_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // frame input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_detect_in,
    input  logic [tcgf_pkg::CONF_W-1:0]     i_conf_in,
    input  logic [tcgf_pkg::STAMP_W-1:0]    i_time_ms,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted,
    output logic                            o_holding,
    output logic                            o_lost_out,
    output logic [tcgf_pkg::VIS_OUT_W-1:0]  o_visibility_level,
    output logic                            o_smoothing_reset,
    output logic [tcgf_pkg::STAMP_W-1:0]    o_last_valid_time,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcgf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcgf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcgf_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // frame sequencer
    tcgf_ctrl #(
        .VIS_FRAC_BITS (VIS_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // gate, hold and fade datapath
    tcgf_dp #(
        .TIME_BITS     (TIME_BITS),
        .VIS_FRAC_BITS (VIS_FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_detect_in        (i_detect_in),
        .i_conf_in          (i_conf_in),
        .i_time_ms          (i_time_ms),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_accepted         (o_accepted),
        .o_holding          (o_holding),
        .o_lost_out         (o_lost_out),
        .o_visibility_level (o_visibility_level),
        .o_smoothing_reset  (o_smoothing_reset),
        .o_last_valid_time  (o_last_valid_time)
    );

endmodule
